[hw/rtl/f2t_pkg.sv]
package f2t_pkg;

  localparam logic [3:0] TT_INT8    = 4'd0;
  localparam logic [3:0] TT_UINT64  = 4'd7;
  localparam logic [3:0] TT_F32     = 4'd8;
  localparam logic [3:0] TT_F64     = 4'd9;
  localparam logic [3:0] TT_CF32    = 4'd10;
  localparam logic [3:0] TT_CF64    = 4'd11;

  localparam logic [63:0] ABS_MASK       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EXP_INF        = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] FLT_MAX_AS_DBL = 64'h47EF_FFFF_E000_0000;
  localparam logic [63:0] QNAN64         = 64'h7FF8_0000_0000_0000;
  localparam logic [31:0] QNAN32         = 32'h7FC0_0000;

  typedef struct packed {
    logic        vld;
    logic [3:0]  tt;
    logic [63:0] re;
    logic [63:0] im;
    logic        last;
  } f2t_s0_t;

  typedef struct packed {
    logic        vld;
    logic [3:0]  tt;
    logic        neg;
    logic        bad;
    logic [63:0] mag;
    logic [30:0] re_f;
    logic [30:0] im_f;
    logic        re_rnd;
    logic        im_rnd;
    logic [63:0] re;
    logic [63:0] im;
    logic        last;
  } f2t_s1_t;

endpackage

[hw/rtl/f2t_f32.sv]
module f2t_f32 (
  input  logic [63:0] x,
  output logic [30:0] trunc_val,
  output logic        rnd_up
);
  import f2t_pkg::*;

  logic [10:0] e;
  logic [52:0] sig;
  logic [11:0] fe;
  logic [5:0]  sh;
  logic [63:0] r;
  logic [63:0] rem;
  logic [63:0] half;
  logic [63:0] lowmask;

  always_comb begin
    e       = x[62:52];
    sig     = {1'b1, x[51:0]};
    fe      = {1'b0, e} - 12'd896;
    sh      = 6'd29;
    trunc_val = '0;
    rnd_up  = 1'b0;
    r       = '0;
    rem     = '0;
    half    = '0;
    lowmask = '0;
    if (e != 11'd0) begin
      if (!fe[11] && fe != 12'd0) begin
        sh = 6'd29;
      end else if (e >= 11'd866) begin
        sh = 6'(12'd926 - {1'b0, e});
      end else begin
        sh = 6'd0;
      end
      if (sh != 6'd0) begin
        r       = {11'd0, sig} >> sh;
        lowmask = (64'd1 << sh) - 64'd1;
        rem     = {11'd0, sig} & lowmask;
        half    = 64'd1 << (sh - 6'd1);
        rnd_up  = (rem > half) || (rem == half && r[0]);
        if (!fe[11] && fe != 12'd0) begin
          trunc_val = {fe[7:0] - 8'd1, 23'd0} + r[30:0];
        end else begin
          trunc_val = r[30:0];
        end
      end
    end
  end

endmodule

[hw/rtl/fp64_to_typed_round_convert_top.sv]
// Converts one IEEE double (or a complex pair) per beat to the type held in
// target_type. A beat is accepted on every cycle (busy is always low) and its
// result is driven with out_valid after passing the register stages below; the
// receiver cannot stall, so results must be taken as they come. The path has
// three register stages: input capture, decode and shift, then rounding and
// range check.
module fp64_to_typed_round_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_real_bits,
  input  logic [63:0] in_imag_bits,
  input  logic        in_last_in,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_target_type,
  output logic        out_valid,
  output logic [63:0] out_result_real,
  output logic [63:0] out_result_imag,
  output logic        out_invalid,
  output logic        out_last_out
);
  import f2t_pkg::*;

  logic [3:0] tt_r;
  f2t_s0_t    s0_r;
  f2t_s1_t    s1_r, s1_nxt;
  logic        vld2_r, inv_r, last2_r;
  logic [63:0] rr_r, ri_r;
  logic [63:0] rr_nxt, ri_nxt;
  logic        inv_nxt;

  logic [30:0] re_f, im_f;
  logic        re_rnd, im_rnd;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tt_r <= TT_F64;
    end else if (cfg_we) begin
      tt_r <= cfg_target_type;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else begin
      s0_r.vld <= start;
    end
    s0_r.tt   <= tt_r;
    s0_r.re   <= in_real_bits;
    s0_r.im   <= in_imag_bits;
    s0_r.last <= in_last_in;
  end

  f2t_f32 u_re (.x(s0_r.re), .trunc_val(re_f), .rnd_up(re_rnd));
  f2t_f32 u_im (.x(s0_r.im), .trunc_val(im_f), .rnd_up(im_rnd));

  logic [10:0] e0;
  logic [52:0] sig0;
  logic [6:0]  ex0;
  logic [5:0]  sh0;

  always_comb begin
    s1_nxt      = '0;
    s1_nxt.vld  = s0_r.vld;
    s1_nxt.tt   = s0_r.tt;
    s1_nxt.re   = s0_r.re;
    s1_nxt.im   = s0_r.im;
    s1_nxt.last = s0_r.last;
    s1_nxt.re_f = re_f;
    s1_nxt.im_f = im_f;
    s1_nxt.re_rnd = re_rnd;
    s1_nxt.im_rnd = im_rnd;
    s1_nxt.neg  = s0_r.re[63];
    e0   = s0_r.re[62:52];
    sig0 = {1'b1, s0_r.re[51:0]};
    ex0  = '0;
    sh0  = '0;
    s1_nxt.bad = (e0 == 11'h7FF) || (e0 > 11'd1086);
    if (!s1_nxt.bad && e0 >= 11'd1022) begin
      ex0 = 7'(e0 - 11'd1022);
      if (ex0 >= 7'd53) begin
        s1_nxt.mag = {11'd0, sig0} << (ex0 - 7'd53);
      end else begin
        sh0 = 6'(7'd53 - ex0);
        s1_nxt.mag = {11'd0, (sig0 >> sh0) + 53'((sig0 >> (sh0 - 6'd1)) & 53'd1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= s1_nxt.vld;
    end
    s1_r.tt     <= s1_nxt.tt;
    s1_r.neg    <= s1_nxt.neg;
    s1_r.bad    <= s1_nxt.bad;
    s1_r.mag    <= s1_nxt.mag;
    s1_r.re_f   <= s1_nxt.re_f;
    s1_r.im_f   <= s1_nxt.im_f;
    s1_r.re_rnd <= s1_nxt.re_rnd;
    s1_r.im_rnd <= s1_nxt.im_rnd;
    s1_r.re     <= s1_nxt.re;
    s1_r.im     <= s1_nxt.im;
    s1_r.last   <= s1_nxt.last;
  end

  logic [6:0]  w;
  logic [63:0] mask, half_rng, limit, sentinel, f32r, f32i;
  logic        sgn, ok_re, ok_im, fin_re, fin_im;

  always_comb begin
    w        = 7'd8 << s1_r.tt[1:0];
    mask     = (w == 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
    half_rng = 64'd1 << (w - 7'd1);
    sgn      = !s1_r.tt[2];
    sentinel = sgn ? half_rng : mask;
    if (sgn) begin
      limit = s1_r.neg ? half_rng : half_rng - 64'd1;
    end else begin
      limit = s1_r.neg ? 64'd0 : mask;
    end
    ok_re  = (s1_r.re & ABS_MASK) <= FLT_MAX_AS_DBL;
    ok_im  = (s1_r.im & ABS_MASK) <= FLT_MAX_AS_DBL;
    fin_re = (s1_r.re & EXP_INF) != EXP_INF;
    fin_im = (s1_r.im & EXP_INF) != EXP_INF;
    f32r   = {32'd0, s1_r.re[63], s1_r.re_f + 31'(s1_r.re_rnd)};
    f32i   = {32'd0, s1_r.im[63], s1_r.im_f + 31'(s1_r.im_rnd)};
    rr_nxt  = '0;
    ri_nxt  = '0;
    inv_nxt = 1'b0;
    if (s1_r.tt <= TT_UINT64) begin
      if (s1_r.bad || s1_r.mag > limit) begin
        rr_nxt  = sentinel;
        inv_nxt = 1'b1;
      end else begin
        rr_nxt = s1_r.neg ? ((64'd0 - s1_r.mag) & mask) : s1_r.mag;
      end
    end else if (s1_r.tt == TT_F32) begin
      if (ok_re) begin
        rr_nxt = f32r;
      end else begin
        rr_nxt  = {32'd0, QNAN32};
        inv_nxt = 1'b1;
      end
    end else if (s1_r.tt == TT_F64) begin
      rr_nxt = fin_re ? s1_r.re : QNAN64;
    end else if (s1_r.tt == TT_CF32) begin
      if (ok_re && ok_im) begin
        rr_nxt = f32r;
        ri_nxt = f32i;
      end else begin
        rr_nxt  = {32'd0, QNAN32};
        ri_nxt  = {32'd0, QNAN32};
        inv_nxt = 1'b1;
      end
    end else if (s1_r.tt == TT_CF64) begin
      if (fin_re && fin_im) begin
        rr_nxt = s1_r.re;
        ri_nxt = s1_r.im;
      end else begin
        rr_nxt = QNAN64;
        ri_nxt = QNAN64;
      end
    end else begin
      inv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= s1_r.vld;
    end
    rr_r    <= rr_nxt;
    ri_r    <= ri_nxt;
    inv_r   <= inv_nxt;
    last2_r <= s1_r.last;
  end

  assign out_valid       = vld2_r;
  assign out_result_real = rr_r;
  assign out_result_imag = ri_r;
  assign out_invalid     = inv_r;
  assign out_last_out    = last2_r;

endmodule

[bench/fp64_to_typed_round_convert_top_test.sv]
`timescale 1ns / 100ps

module fp64_to_typed_round_convert_top_test;
  import f2t_pkg::*;

  localparam logic [3:0] TT_UINT8 = 4'd4;
  localparam logic [3:0] TT_LAST_CODE = 4'd15;
  localparam int LATENCY = 3;

  typedef struct {
    logic [63:0] re;
    logic [63:0] im;
    logic        inv;
    logic        last;
  } conv_result_t;

  class conv_scoreboard;
    conv_result_t pending[$];
    logic [3:0] target = TT_F64;
    int mismatches = 0;

    function automatic logic [63:0] to_int(logic [63:0] x, int w, bit sgn, ref logic inv);
      logic [63:0] mask, half, sentinel, mag, limit, sig;
      int e, ex, sh;
      mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      half = 64'd1 << (w - 1);
      sentinel = sgn ? half : mask;
      e = x[62:52];
      mag = '0;
      if (e == 'h7FF || e > 1086) begin
        inv = 1'b1;
        return sentinel;
      end
      if (e >= 1022) begin
        sig = {11'd0, 1'b1, x[51:0]};
        ex = e - 1022;
        if (ex >= 53) begin
          mag = sig << (ex - 53);
        end else begin
          sh = 53 - ex;
          mag = (sig >> sh) + ((sig >> (sh - 1)) & 64'd1);
        end
      end
      if (sgn) limit = x[63] ? half : half - 64'd1;
      else limit = x[63] ? 64'd0 : mask;
      if (mag > limit) begin
        inv = 1'b1;
        return sentinel;
      end
      return x[63] ? ((64'd0 - mag) & mask) : mag;
    endfunction

    function automatic bit fits_f32(logic [63:0] x);
      return (x & ABS_MASK) <= FLT_MAX_AS_DBL;
    endfunction

    function automatic logic [63:0] to_f32(logic [63:0] x);
      logic [63:0] sgn, sig, base, r, rem, half;
      int e, fe, sh;
      sgn = {32'd0, x[63], 31'd0};
      e = x[62:52];
      if (e == 0) return sgn;
      sig = {11'd0, 1'b1, x[51:0]};
      fe = e - 1023 + 127;
      if (fe >= 1) begin
        sh = 29;
        base = 64'(fe - 1) << 23;
      end else begin
        if (30 - fe > 60) return sgn;
        sh = 30 - fe;
        base = '0;
      end
      r = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && r[0])) r = r + 64'd1;
      return sgn | (base + r);
    endfunction

    function automatic bit finite64(logic [63:0] x);
      return (x & EXP_INF) != EXP_INF;
    endfunction

    function void note_beat(logic [63:0] re, logic [63:0] im, logic last);
      conv_result_t c;
      c.re = '0;
      c.im = '0;
      c.inv = 1'b0;
      c.last = last;
      if (target <= TT_UINT64) begin
        c.re = to_int(re, 8 << target[1:0], target < TT_UINT8, c.inv);
      end else if (target == TT_F32) begin
        if (fits_f32(re)) begin
          c.re = to_f32(re);
        end else begin
          c.re = {32'd0, QNAN32};
          c.inv = 1'b1;
        end
      end else if (target == TT_F64) begin
        c.re = finite64(re) ? re : QNAN64;
      end else if (target == TT_CF32) begin
        if (fits_f32(re) && fits_f32(im)) begin
          c.re = to_f32(re);
          c.im = to_f32(im);
        end else begin
          c.re = {32'd0, QNAN32};
          c.im = {32'd0, QNAN32};
          c.inv = 1'b1;
        end
      end else if (target == TT_CF64) begin
        if (finite64(re) && finite64(im)) begin
          c.re = re;
          c.im = im;
        end else begin
          c.re = QNAN64;
          c.im = QNAN64;
        end
      end else begin
        c.inv = 1'b1;
      end
      pending.push_back(c);
    endfunction

    function void check_beat(conv_result_t got);
      conv_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: re=%h", got.re);
        return;
      end
      exp_r = pending.pop_front();
      if (got.re !== exp_r.re || got.im !== exp_r.im || got.inv !== exp_r.inv ||
          got.last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: exp re=%h im=%h inv=%b last=%b, got re=%h im=%h inv=%b last=%b",
                   exp_r.re, exp_r.im, exp_r.inv, exp_r.last,
                   got.re, got.im, got.inv, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_real_bits = '0;
  logic [63:0] in_imag_bits = '0;
  logic        in_last_in = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_target_type = '0;
  logic        out_valid;
  logic [63:0] out_result_real;
  logic [63:0] out_result_imag;
  logic        out_invalid;
  logic        out_last_out;

  conv_scoreboard sb = new();

  fp64_to_typed_round_convert_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_real_bits(in_real_bits), .in_imag_bits(in_imag_bits), .in_last_in(in_last_in),
    .cfg_we(cfg_we), .cfg_target_type(cfg_target_type),
    .out_valid(out_valid), .out_result_real(out_result_real),
    .out_result_imag(out_result_imag), .out_invalid(out_invalid),
    .out_last_out(out_last_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    conv_result_t got;
    if (rst_n && out_valid) begin
      got.re = out_result_real;
      got.im = out_result_imag;
      got.inv = out_invalid;
      got.last = out_last_out;
      sb.check_beat(got);
    end
  end

  function automatic logic [63:0] rand_double();
    logic [63:0] x;
    int pick;
    x = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 5) x[62:52] = 11'($urandom_range(1010, 1090));
    else if (pick < 7) x[62:52] = 11'($urandom_range(860, 1160));
    else if (pick == 7) x[62:52] = ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h000;
    if ($urandom_range(0, 3) == 0) x[40:0] = '0;
    if ($urandom_range(0, 9) == 0) x[62:0] = FLT_MAX_AS_DBL[62:0] + 63'($urandom_range(0, 2)) - 63'd1;
    return x;
  endfunction

  task automatic send_beat(logic [63:0] re, logic [63:0] im);
    int gap;
    start <= 1'b1;
    in_real_bits <= re;
    in_imag_bits <= im;
    in_last_in <= 1'($urandom_range(0, 1));
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(in_real_bits, in_imag_bits, in_last_in);
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_target(logic [3:0] t);
    cfg_we <= 1'b1;
    cfg_target_type <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.target = t;
    @(posedge clk);
  endtask

  logic [63:0] corner[$] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FE0_0000_0000_0000,
    64'hBFE0_0000_0000_0000, 64'h3FF8_0000_0000_0000, 64'h4004_0000_0000_0000,
    64'h405F_E000_0000_0000, 64'hC060_1000_0000_0000, 64'h43E0_0000_0000_0000,
    64'hC3E0_0000_0000_0000, 64'h43F0_0000_0000_0000, 64'h43EF_FFFF_FFFF_FFFF,
    64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h47EF_FFFF_E000_0000,
    64'h47EF_FFFF_E000_0001, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
    64'h3810_0000_0000_0000, 64'h36A0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF
  };

  initial begin
    logic [3:0] order[$];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int t = 0; t <= TT_LAST_CODE; t++) order.push_back(4'(t));
    order.push_back(TT_UINT64);
    order.push_back(TT_CF32);
    for (int p = -1; p < order.size(); p++) begin
      if (p >= 0) set_target(order[p]);
      if (p <= 0) begin
        foreach (corner[i]) send_beat(corner[i], corner[corner.size() - 1 - i]);
      end
      repeat (55) send_beat(rand_double(), rand_double());
      drain();
    end
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
